[hdl/wmms_pkg.sv]
// Package for the window min/max/mean/std block: payload structs, constants
// and the lane result and control structs. No dependencies.
`default_nettype none
package wmms_pkg;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned STD_W  = 31;
    localparam int unsigned SUM_W  = 48;
    localparam int unsigned SQ_W   = 128;
    localparam int unsigned CNT_W  = 17;
    localparam int unsigned LOG_W  = 5;
    localparam int unsigned MAX_LOG = 16;
    localparam logic signed [DATA_W-1:0] FULL_SCALE_POS = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] FULL_SCALE_NEG = 32'sh8000_0000;
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_GAP    = 1'b1;
    localparam logic [LOG_W-1:0] LOG_RESET = 5'd6;
    localparam logic [1:0] ADDR_DECIM = 2'd0;

    typedef struct packed {
        logic               command;
        logic signed [31:0] x_sample;
        logic signed [31:0] y_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] max_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_y;
        logic signed [31:0] mean_x;
        logic signed [31:0] mean_y;
        logic [30:0]        std_x;
        logic [30:0]        std_y;
    } out_item_t;

    // result of one axis lane at the end of a window
    typedef struct packed {
        logic signed [DATA_W-1:0] min_v;
        logic signed [DATA_W-1:0] max_v;
        logic [SUM_W-1:0]         sum;
        logic [SQ_W-1:0]          sumsq;
    } lane_res_t;

    // control from the top to each lane
    typedef struct packed {
        logic take;
        logic clear;
    } lane_ctl_t;
endpackage
`default_nettype wire

[hdl/window_min_max_mean_std.sv]
// Top level of the window min/max/mean/std block: handshake, register port,
// two axis lanes and the merge unit. Depends on wmms_pkg, wmms_lane, wmms_stat.
//
// Usage: samples enter on in_valid/in_ready as one in_item_t per transfer.
// Each sample is folded into the x and y lanes as it is taken. The sample that
// closes a window of 2^n samples starts the merge unit, which squares the
// sums in states S_SQ0 to S_SQ2, forms the variance in S_VAR and extracts both
// roots one bit per cycle in S_ROOT; out_valid is registered from its done
// strobe. Input is refused while the merge unit runs and again while a result
// waits, so the next window's samples are not taken until the merge is through.
// A gap command drops the partial window and yields no result.
// A stalled receiver holds out_valid and the result until out_ready.
// Reset clears all accumulators and sets the window exponent register to 6.
// The register port is APB-style; the window exponent is at address 0.
`default_nettype none
module window_min_max_mean_std #(
    parameter int unsigned MAX_DECIMATION_LOG2 = 16,
    parameter int unsigned SAMPLE_BITS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire wmms_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output wmms_pkg::out_item_t      out_data,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [1:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    logic [4:0] log_reg, n;
    logic [16:0] cnt_reg;
    logic [16:0] cnt_next;
    logic take, fire, close, busy, done, ovalid_reg;
    wmms_pkg::lane_ctl_t ctl;
    wmms_pkg::lane_res_t rx, ry;
    wmms_pkg::out_item_t res;
    wmms_pkg::out_item_t out_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == wmms_pkg::ADDR_DECIM) ? {27'd0, log_reg} : 32'd0;
    assign n = (log_reg == 5'd0) ? 5'd1 :
               (log_reg > 5'(MAX_DECIMATION_LOG2)) ? 5'(MAX_DECIMATION_LOG2) : log_reg;

    assign in_ready = !busy && !ovalid_reg;
    assign take  = in_valid && in_ready;
    assign fire  = take && (in_data.command == wmms_pkg::CMD_SAMPLE);
    assign cnt_next = cnt_reg + 17'd1;
    assign close = fire && (cnt_next >= (17'd1 << n));
    assign ctl.take  = fire;
    assign ctl.clear = close || (take && in_data.command == wmms_pkg::CMD_GAP);

    wmms_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sample(in_data.x_sample), .res(rx));
    wmms_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sample(in_data.y_sample), .res(ry));
    wmms_stat u_stat (
        .clk(clk), .rst_n(rst_n), .start(close), .n(n), .rx(rx), .ry(ry),
        .busy(busy), .done(done), .result(res));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_reg    <= wmms_pkg::LOG_RESET;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
            out_reg    <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == wmms_pkg::ADDR_DECIM)
                log_reg <= pwdata[4:0];
            if (ctl.clear)
                cnt_reg <= '0;
            else if (fire)
                cnt_reg <= cnt_next;
            // hold the result until the transfer
            if (done)
            begin
                ovalid_reg <= 1'b1;
                out_reg    <= res;
            end
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_data  = out_reg;
endmodule
`default_nettype wire

[hdl/wmms_lane.sv]
// One axis accumulator lane: running min, max, sum and sum of squares.
// Depends on wmms_pkg.
`default_nettype none
module wmms_lane #(
    parameter int unsigned SAMPLE_BITS = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire wmms_pkg::lane_ctl_t       ctl,
    input  wire logic signed [31:0]        sample,
    output wmms_pkg::lane_res_t            res
);
    logic signed [31:0] v;
    logic [31:0] mag;
    logic [63:0] sq;
    logic signed [31:0] min_reg, max_reg;
    logic [47:0] sum_reg;
    logic [127:0] sq_reg;

    assign v   = 32'(signed'(sample[SAMPLE_BITS-1:0]));
    assign mag = v[31] ? 32'(-v) : v;
    assign sq  = mag * mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= wmms_pkg::FULL_SCALE_POS;
            max_reg <= wmms_pkg::FULL_SCALE_NEG;
            sum_reg <= '0;
            sq_reg  <= '0;
        end
        else if (ctl.clear)
        begin
            min_reg <= wmms_pkg::FULL_SCALE_POS;
            max_reg <= wmms_pkg::FULL_SCALE_NEG;
            sum_reg <= '0;
            sq_reg  <= '0;
        end
        else if (ctl.take)
        begin
            if (v < min_reg) min_reg <= v;
            if (v > max_reg) max_reg <= v;
            sum_reg <= sum_reg + 48'(v);
            sq_reg  <= sq_reg + 128'(sq);
        end
    end

    // combined with the current sample, for the closing transfer
    always_comb
    begin
        res.min_v = (v < min_reg) ? v : min_reg;
        res.max_v = (v > max_reg) ? v : max_reg;
        res.sum   = sum_reg + 48'(v);
        res.sumsq = sq_reg + 128'(sq);
    end
endmodule
`default_nettype wire

[hdl/wmms_stat.sv]
// End-of-window merge for both lanes: mean, variance and a bit-serial
// square root per axis. Depends on wmms_pkg.
`default_nettype none
module wmms_stat (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [4:0]           n,
    input  wire wmms_pkg::lane_res_t  rx,
    input  wire wmms_pkg::lane_res_t  ry,
    output logic                      busy,
    output logic                      done,
    output wmms_pkg::out_item_t       result
);
    localparam logic [2:0] S_IDLE = 3'd0, S_SQ0 = 3'd1, S_SQ1 = 3'd2,
                           S_SQ2 = 3'd3, S_VAR = 3'd4, S_ROOT = 3'd5;
    logic [2:0] st_reg;
    logic [4:0] n_reg;
    wmms_pkg::lane_res_t x_reg, y_reg;
    logic [47:0] magx_reg, magy_reg;
    logic [127:0] s2x_reg, s2y_reg;
    logic [127:0] remx_reg, remy_reg;
    logic [63:0] rx_reg, ry_reg;
    logic [6:0] bit_reg;
    logic zx_reg, zy_reg;
    logic [127:0] scx, scy, tx, ty;
    logic [63:0] px, py;
    logic [63:0] fx, fy;

    assign scx = (x_reg.sumsq >> n_reg) << (2 * n_reg);
    assign scy = (y_reg.sumsq >> n_reg) << (2 * n_reg);
    // magnitude split in 24-bit halves: 24x24 products in S_SQ0, S_SQ1 and S_SQ2
    always_comb
    begin
        px = '0; py = '0;
        case (st_reg)
            S_SQ0:   begin px = magx_reg[23:0] * magx_reg[23:0];
                           py = magy_reg[23:0] * magy_reg[23:0]; end
            S_SQ1:   begin px = magx_reg[23:0] * magx_reg[47:24];
                           py = magy_reg[23:0] * magy_reg[47:24]; end
            S_SQ2:   begin px = magx_reg[47:24] * magx_reg[47:24];
                           py = magy_reg[47:24] * magy_reg[47:24]; end
            default: begin px = '0; py = '0; end
        endcase
    end
    // restoring root: try bit b, compare (2r+2^b)*2^b against remainder
    always_comb
    begin
        tx = ({64'b0, rx_reg} << (bit_reg[5:0] + 7'd1)) | (128'd1 << (2 * bit_reg[5:0]));
        ty = ({64'b0, ry_reg} << (bit_reg[5:0] + 7'd1)) | (128'd1 << (2 * bit_reg[5:0]));
        fx = rx_reg >> n_reg;
        fy = ry_reg >> n_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            done     <= 1'b0;
            n_reg    <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            magx_reg <= '0;
            magy_reg <= '0;
            s2x_reg  <= '0;
            s2y_reg  <= '0;
            remx_reg <= '0;
            remy_reg <= '0;
            rx_reg   <= '0;
            ry_reg   <= '0;
            bit_reg  <= '0;
            zx_reg   <= 1'b0;
            zy_reg   <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (st_reg)
                S_IDLE:
                    if (start)
                    begin
                        st_reg   <= S_SQ0;
                        n_reg    <= n;
                        x_reg    <= rx;
                        y_reg    <= ry;
                        magx_reg <= rx.sum[47] ? -rx.sum : rx.sum;
                        magy_reg <= ry.sum[47] ? -ry.sum : ry.sum;
                    end
                S_SQ0:
                begin
                    s2x_reg <= 128'(px);
                    s2y_reg <= 128'(py);
                    st_reg  <= S_SQ1;
                end
                S_SQ1:
                begin
                    s2x_reg <= s2x_reg + (128'(px) << 25);
                    s2y_reg <= s2y_reg + (128'(py) << 25);
                    st_reg  <= S_SQ2;
                end
                S_SQ2:
                begin
                    s2x_reg <= s2x_reg + (128'(px) << 48);
                    s2y_reg <= s2y_reg + (128'(py) << 48);
                    st_reg  <= S_VAR;
                end
                S_VAR:
                begin
                    zx_reg   <= (scx <= s2x_reg);
                    zy_reg   <= (scy <= s2y_reg);
                    remx_reg <= scx - s2x_reg;
                    remy_reg <= scy - s2y_reg;
                    rx_reg   <= '0;
                    ry_reg   <= '0;
                    bit_reg  <= 7'd63;
                    st_reg   <= S_ROOT;
                end
                S_ROOT:
                begin
                    if (tx <= remx_reg)
                    begin
                        remx_reg <= remx_reg - tx;
                        rx_reg   <= rx_reg | (64'd1 << bit_reg[5:0]);
                    end
                    if (ty <= remy_reg)
                    begin
                        remy_reg <= remy_reg - ty;
                        ry_reg   <= ry_reg | (64'd1 << bit_reg[5:0]);
                    end
                    if (bit_reg == 7'd0)
                    begin
                        st_reg <= S_IDLE;
                        done   <= 1'b1;
                    end
                    bit_reg <= bit_reg - 7'd1;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (st_reg != S_IDLE);

    always_comb
    begin
        result.min_x  = x_reg.min_v;
        result.max_x  = x_reg.max_v;
        result.min_y  = y_reg.min_v;
        result.max_y  = y_reg.max_v;
        result.mean_x = 32'($signed(x_reg.sum) >>> n_reg);
        result.mean_y = 32'($signed(y_reg.sum) >>> n_reg);
        result.std_x  = zx_reg ? 31'd0 : ((fx > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : fx[30:0]);
        result.std_y  = zy_reg ? 31'd0 : ((fy > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : fy[30:0]);
    end
endmodule
`default_nettype wire

[hdl/wmms_check.sv]
// Port-level checker for window_min_max_mean_std, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none
module wmms_check (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic pready
);
    // a pending result blocks new input
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready) else $error("pready low");
    a_once: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid) else $error("result repeated");
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid) else $error("input withdrawn");
endmodule
bind window_min_max_mean_std wmms_check u_check (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .pready(pready));
`default_nettype wire

[verif/window_min_max_mean_std_tb.sv]
// Testbench for window_min_max_mean_std: directed and random sample/gap streams,
// APB writes of the window exponent, and an in-line predictor checked on every output.
// Depends on wmms_pkg and the window_min_max_mean_std RTL.
module window_min_max_mean_std_tb;
    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int unsigned DRAIN_CYCLES = 120;

    typedef struct {
        logic signed [31:0] lo_v;
        logic signed [31:0] hi_v;
        logic [47:0]        sum;
        logic [127:0]       sq;
    } axis_acc_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    wmms_pkg::in_item_t  in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    wmms_pkg::out_item_t out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    wmms_pkg::in_item_t  pending_samples[$];
    wmms_pkg::out_item_t window_results[$];
    axis_acc_t   acc_x, acc_y;
    logic [16:0] window_count;
    logic [4:0]  decim_shadow = wmms_pkg::LOG_RESET;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned windows_checked = 0;
    int unsigned samples_taken = 0;
    int unsigned gaps_taken = 0;
    int unsigned cycles = 0;

    window_min_max_mean_std DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    function automatic axis_acc_t empty_axis();
        axis_acc_t a;
        a.lo_v = wmms_pkg::FULL_SCALE_POS;
        a.hi_v = wmms_pkg::FULL_SCALE_NEG;
        a.sum = '0;
        a.sq = '0;
        return a;
    endfunction

    function automatic void clear_windows();
        acc_x = empty_axis();
        acc_y = empty_axis();
        window_count = '0;
    endfunction

    function automatic axis_acc_t fold_axis(axis_acc_t a, logic signed [31:0] v);
        logic [63:0] mag;
        mag = v[31] ? 64'(-64'(signed'(v))) : 64'(v);
        if (v < a.lo_v) a.lo_v = v;
        if (v > a.hi_v) a.hi_v = v;
        a.sum = a.sum + 48'(signed'(v));
        a.sq = a.sq + 128'(mag * mag);
        return a;
    endfunction

    function automatic logic [63:0] isqrt128(logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  t;
        logic [127:0] p;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            p = {64'b0, t} * {64'b0, t};
            if (p <= v) r = t;
        end
        return r;
    endfunction

    function automatic logic [31:0] axis_mean(logic [47:0] sum, int n);
        logic signed [63:0] e;
        e = 64'(signed'(sum));
        e = e >>> n;
        return e[31:0];
    endfunction

    function automatic logic [30:0] axis_std(logic [127:0] sq, logic [47:0] sum, int n);
        logic signed [63:0] e;
        logic [63:0]        mag;
        logic [127:0]       scaled;
        logic [127:0]       sum2;
        logic [63:0]        root;
        e = 64'(signed'(sum));
        mag = e[63] ? 64'(-e) : 64'(e);
        scaled = (sq >> n) << (2 * n);
        sum2 = {64'b0, mag} * {64'b0, mag};
        if (scaled <= sum2) return '0;
        root = isqrt128(scaled - sum2) >> n;
        return (root > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : root[30:0];
    endfunction

    // Fold one accepted transfer into the window and queue the result it closes.
    function automatic void predict_window(wmms_pkg::in_item_t it);
        int n;
        wmms_pkg::out_item_t r;
        n = decim_shadow;
        if (n < 1) n = 1;
        if (n > wmms_pkg::MAX_LOG) n = wmms_pkg::MAX_LOG;
        if (it.command == wmms_pkg::CMD_GAP) begin
            gaps_taken++;
            clear_windows();
            return;
        end
        samples_taken++;
        acc_x = fold_axis(acc_x, it.x_sample);
        acc_y = fold_axis(acc_y, it.y_sample);
        window_count = window_count + 17'd1;
        if (window_count < (17'd1 << n)) return;
        r.min_x = acc_x.lo_v;
        r.max_x = acc_x.hi_v;
        r.min_y = acc_y.lo_v;
        r.max_y = acc_y.hi_v;
        r.mean_x = axis_mean(acc_x.sum, n);
        r.mean_y = axis_mean(acc_y.sum, n);
        r.std_x = axis_std(acc_x.sq, acc_x.sum, n);
        r.std_y = axis_std(acc_y.sq, acc_y.sum, n);
        window_results.push_back(r);
        clear_windows();
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %0s: got %h expected %h (window %0d)", field, got, want,
                 windows_checked);
        mismatches++;
    endtask

    // Driver: advance to the next pending transfer, or idle at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data <= pending_samples.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predict on input transfers, check output transfers.
    always @(posedge clk)
    begin
        wmms_pkg::out_item_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_window(in_data);
            if (out_valid && out_ready)
            begin
                if (window_results.size() == 0)
                begin
                    report_mismatch("unexpected result", out_data.min_x, 32'd0);
                end
                else
                begin
                    want = window_results.pop_front();
                    if (out_data.min_x !== want.min_x)
                        report_mismatch("min_x", out_data.min_x, want.min_x);
                    if (out_data.max_x !== want.max_x)
                        report_mismatch("max_x", out_data.max_x, want.max_x);
                    if (out_data.min_y !== want.min_y)
                        report_mismatch("min_y", out_data.min_y, want.min_y);
                    if (out_data.max_y !== want.max_y)
                        report_mismatch("max_y", out_data.max_y, want.max_y);
                    if (out_data.mean_x !== want.mean_x)
                        report_mismatch("mean_x", out_data.mean_x, want.mean_x);
                    if (out_data.mean_y !== want.mean_y)
                        report_mismatch("mean_y", out_data.mean_y, want.mean_y);
                    if (out_data.std_x !== want.std_x)
                        report_mismatch("std_x", 32'(out_data.std_x), 32'(want.std_x));
                    if (out_data.std_y !== want.std_y)
                        report_mismatch("std_y", 32'(out_data.std_y), 32'(want.std_y));
                    windows_checked++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", window_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0: return wmms_pkg::FULL_SCALE_POS;
            1: return wmms_pkg::FULL_SCALE_NEG;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return 32'(signed'($urandom_range(200)) - 100);
            5: return 32'(signed'($urandom_range(2000000)) + 1000000);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_sample(logic signed [31:0] x, logic signed [31:0] y);
        wmms_pkg::in_item_t it;
        it.command = wmms_pkg::CMD_SAMPLE;
        it.x_sample = x;
        it.y_sample = y;
        pending_samples.push_back(it);
    endtask

    task automatic push_gap();
        wmms_pkg::in_item_t it;
        it.command = wmms_pkg::CMD_GAP;
        it.x_sample = $urandom;
        it.y_sample = $urandom;
        pending_samples.push_back(it);
    endtask

    // Hold until every transfer is sent and every result is back, then let the
    // merge unit settle.
    task automatic wait_idle();
        while (pending_samples.size() > 0 || in_valid || window_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_decimation(logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= wmms_pkg::ADDR_DECIM;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        decim_shadow = value[4:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial
    begin
        int unsigned idle_modes[4][2];
        int unsigned log_choices[8];
        clear_windows();
        idle_modes = '{'{0, 0}, '{54, 0}, '{0, 54}, '{24, 24}};
        log_choices = '{1, 2, 3, 4, 5, 0, 7, 2};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset value of the register: one 64-sample window
        for (int i = 0; i < 64; i++)
            push_sample(pick_value(), pick_value());
        wait_idle();

        // directed extremes with two-sample windows
        write_decimation(1);
        push_sample(wmms_pkg::FULL_SCALE_POS, wmms_pkg::FULL_SCALE_NEG);
        push_sample(wmms_pkg::FULL_SCALE_NEG, wmms_pkg::FULL_SCALE_POS);
        push_sample(wmms_pkg::FULL_SCALE_POS, wmms_pkg::FULL_SCALE_POS);
        push_sample(wmms_pkg::FULL_SCALE_POS, wmms_pkg::FULL_SCALE_POS);
        push_sample(wmms_pkg::FULL_SCALE_NEG, wmms_pkg::FULL_SCALE_NEG);
        push_sample(wmms_pkg::FULL_SCALE_NEG, wmms_pkg::FULL_SCALE_NEG);
        push_sample(0, -1);
        push_sample(-1, 0);
        push_sample(3, -3);
        push_gap();
        push_sample(-7, 7);
        push_sample(-8, 8);
        push_gap();
        push_gap();
        push_sample(32'h5555_5555, 32'hAAAA_AAAA);
        push_sample(32'hAAAA_AAAA, 32'h5555_5555);
        wait_idle();

        // zero is used as one
        write_decimation(0);
        push_sample(100, -100);
        push_sample(101, -99);
        wait_idle();

        // change the register with a partial window held
        write_decimation(4);
        for (int i = 0; i < 10; i++)
            push_sample(pick_value(), pick_value());
        wait_idle();
        write_decimation(2);
        push_sample(wmms_pkg::FULL_SCALE_NEG, 5);
        wait_idle();

        // above the maximum is clamped; drop the partial window
        write_decimation(31);
        for (int i = 0; i < 5; i++)
            push_sample(pick_value(), pick_value());
        push_gap();
        wait_idle();

        // one 32-sample window with extremes alternating
        write_decimation(5);
        for (int i = 0; i < 32; i++)
        begin
            if (i % 2 == 1)
                push_sample(wmms_pkg::FULL_SCALE_POS, wmms_pkg::FULL_SCALE_NEG);
            else
                push_sample(wmms_pkg::FULL_SCALE_NEG,
                            (i % 3 == 0) ? wmms_pkg::FULL_SCALE_NEG
                                         : wmms_pkg::FULL_SCALE_POS);
        end
        wait_idle();

        // random phases over idle patterns and window sizes
        for (int ph = 0; ph < 12; ph++)
        begin
            send_idle_pct = idle_modes[ph % 4][0];
            recv_stall_pct = idle_modes[ph % 4][1];
            write_decimation(log_choices[$urandom_range(7)]);
            for (int i = 0; i < 155; i++)
            begin
                if ($urandom_range(99) < 4)
                    push_gap();
                else
                    push_sample(pick_value(), pick_value());
            end
            wait_idle();
        end

        $display("covered %0d samples and %0d gaps, %0d windows checked",
                 samples_taken, gaps_taken, windows_checked);
        $display("window sizes 2 to 128, register clamping, mid-window changes");
        if (mismatches == 0 && window_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
